// ===== rtl/rf_generator_fault_monitor_defines.svh =====
// assertion macros used by the rf generator fault monitor checker
// no dependencies; included by the checker file
`ifndef RF_GENERATOR_FAULT_MONITOR_DEFINES_SVH
`define RF_GENERATOR_FAULT_MONITOR_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define RFGFM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rfgfm check failed");

// next-cycle implication, masked while reset is asserted
`define RFGFM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rfgfm check failed");

// next-cycle implication that also holds through reset
`define RFGFM_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rfgfm check failed");

`endif

// ===== rtl/rfgfm_pkg.sv =====
// shared widths, codes, stage record and helpers of the rf generator fault monitor
// no dependencies
package rfgfm_pkg;

    localparam int POWER_BITS = 16;
    localparam int PCT_W      = 7;
    localparam int LIM_W      = 8;
    localparam int CNT_W      = 8;
    localparam int ST_W       = 3;
    localparam int PH_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    // setpoint times percent, also holds 100 times any power value
    localparam int PROD_W     = POWER_BITS + PCT_W;

    // stream widths: rf_on, setpoint, plasma_seen, load_power, reflect_power
    localparam int S_FIELDS_W = 3 * POWER_BITS + 2;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 2;
    localparam int M_FIELDS_W = ST_W + 3 * CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [PROD_W-1:0] PCT_DIV = PROD_W'(100);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POWER_TOL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLASMA_LIM  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_LIM   = 2'd3;

    // phases
    localparam logic [PH_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PH_W-1:0] PH_MON  = 2'd1;
    localparam logic [PH_W-1:0] PH_HALT = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [ST_W-1:0] ST_OK       = 3'd1;
    localparam logic [ST_W-1:0] ST_NOPLASMA = 3'd2;
    localparam logic [ST_W-1:0] ST_POWER    = 3'd3;
    localparam logic [ST_W-1:0] ST_REFLECT  = 3'd4;
    localparam logic [ST_W-1:0] ST_ABORT    = 3'd5;

    // one tick after the first stage: flags plus scaled values
    typedef struct packed {
        logic              start;
        logic              stop;
        logic              rf_active;
        logic              plasma;
        logic [PROD_W-1:0] prod_power;
        logic [PROD_W-1:0] prod_reflect;
        logic [PROD_W-1:0] diff_x100;
        logic [PROD_W-1:0] reflect_x100;
    } tick_t;

    // saturating counter step
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
        return r;
    endfunction

endpackage

// ===== rtl/rfgfm_prep.sv =====
// first stage: registers one tick with setpoint products and scaled measurements
// depends on rfgfm_pkg
module rfgfm_prep (
    input  logic                           aclk,
    input  logic                           load,
    input  logic                           start_cmd,
    input  logic                           stop_cmd,
    input  logic                           rf_on,
    input  logic [rfgfm_pkg::POWER_BITS-1:0] setpoint,
    input  logic                           plasma_seen,
    input  logic [rfgfm_pkg::POWER_BITS-1:0] load_power,
    input  logic [rfgfm_pkg::POWER_BITS-1:0] reflect_power,
    input  logic [rfgfm_pkg::PCT_W-1:0]      power_tol,
    input  logic [rfgfm_pkg::PCT_W-1:0]      reflect_tol,
    output rfgfm_pkg::tick_t                 tick
);
    import rfgfm_pkg::*;

    logic [POWER_BITS-1:0] diff;
    tick_t                 tick_next;
    tick_t                 tick_reg;

    // bands are compared as products, so band > x becomes prod >= 100 * (x + 1)
    always_comb begin
        diff = (load_power > setpoint) ? load_power - setpoint : setpoint - load_power;
        tick_next.start        = start_cmd;
        tick_next.stop         = stop_cmd;
        tick_next.rf_active    = rf_on && (setpoint != '0);
        tick_next.plasma       = plasma_seen;
        tick_next.prod_power   = PROD_W'(setpoint) * PROD_W'(power_tol);
        tick_next.prod_reflect = PROD_W'(setpoint) * PROD_W'(reflect_tol);
        tick_next.diff_x100    = PROD_W'(diff) * PCT_DIV;
        tick_next.reflect_x100 = PROD_W'(reflect_power) * PCT_DIV;
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            tick_reg <= tick_next;
        end
    end

    assign tick = tick_reg;

endmodule

// ===== rtl/rf_generator_fault_monitor.sv =====
// top level of the rf generator fault monitor: stream ports, config registers, fault state
// depends on rfgfm_pkg and rfgfm_prep
//
// Takes one monitoring tick per clock cycle while the output is not stalled and returns one
// result per tick. The first stage registers the setpoint-times-percent products and the
// scaled power difference and reflected power; the second stage compares them and updates
// the fault counters, and its state registers are the result itself. A stalled result
// stalls the first stage only once that stage is also full, so the block still takes one
// request while a result waits. Bands are kept as the product of setpoint and percent, so
// a band of floor(setpoint * percent / 100) needs no divider.
module rf_generator_fault_monitor (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input ticks
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // rf_on [0], setpoint [16:1], plasma_seen [17], load_power [33:18],
    // reflect_power [49:34], zero fill above
    input  logic [rfgfm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // start_cmd [0], stop_cmd [1]
    input  logic [rfgfm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status [2:0], plasma_fault_count [10:3], power_fault_count [18:11],
    // reflect_fault_count [26:19], zero fill above
    output logic [rfgfm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rfgfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfgfm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rfgfm_pkg::*;

    localparam int P = POWER_BITS;

    // configuration registers
    logic [PCT_W-1:0] power_tol_reg, reflect_tol_reg;
    logic [LIM_W-1:0] plasma_lim_reg, power_lim_reg;

    // pipeline control
    logic  s1_valid_reg, s1_valid_next;
    logic  m_valid_reg, m_valid_next;
    logic  out_free, take, move;
    tick_t tick;

    // monitor state, also the result payload
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [PROD_W-1:0] band_power_reg, band_power_next;
    logic [PROD_W-1:0] band_reflect_reg, band_reflect_next;
    logic [CNT_W-1:0]  plasma_cnt_reg, plasma_cnt_next;
    logic [CNT_W-1:0]  power_cnt_reg, power_cnt_next;
    logic [CNT_W-1:0]  reflect_cnt_reg, reflect_cnt_next;
    logic              halted;

    // handshake
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign move          = s1_valid_reg && out_free;
    assign cfg_ready     = 1'b1;

    assign s1_valid_next = take ? 1'b1 : (move ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = move ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    rfgfm_prep u_prep (
        .aclk          (aclk),
        .load          (take),
        .start_cmd     (s_axis_tuser[0]),
        .stop_cmd      (s_axis_tuser[1]),
        .rf_on         (s_axis_tdata[0]),
        .setpoint      (s_axis_tdata[P:1]),
        .plasma_seen   (s_axis_tdata[P+1]),
        .load_power    (s_axis_tdata[2*P+1:P+2]),
        .reflect_power (s_axis_tdata[3*P+1:2*P+2]),
        .power_tol     (power_tol_reg),
        .reflect_tol   (reflect_tol_reg),
        .tick          (tick)
    );

    // tick evaluation: start, then checks in order, then stop
    always_comb begin
        phase_next        = phase_reg;
        status_next       = status_reg;
        band_power_next   = band_power_reg;
        band_reflect_next = band_reflect_reg;
        plasma_cnt_next   = plasma_cnt_reg;
        power_cnt_next    = power_cnt_reg;
        reflect_cnt_next  = reflect_cnt_reg;
        halted            = 1'b0;

        if (tick.start) begin
            band_power_next   = tick.prod_power;
            band_reflect_next = tick.prod_reflect;
            plasma_cnt_next   = '0;
            power_cnt_next    = '0;
            reflect_cnt_next  = '0;
            phase_next        = PH_MON;
            status_next       = ST_OK;
        end

        if (phase_next == PH_MON) begin
            if (!tick.rf_active) begin
                plasma_cnt_next = '0;
                power_cnt_next  = '0;
            end else begin
                // missing plasma
                if (!tick.plasma) begin
                    plasma_cnt_next = sat_inc(plasma_cnt_next);
                    if (plasma_cnt_next > plasma_lim_reg) begin
                        halted      = 1'b1;
                        status_next = ST_NOPLASMA;
                    end
                end else begin
                    plasma_cnt_next = '0;
                end
                // load power out of band, skipped for an empty band
                if (!halted && band_power_next >= PCT_DIV) begin
                    if (band_power_next < tick.diff_x100) begin
                        power_cnt_next = sat_inc(power_cnt_next);
                        if (power_cnt_next > power_lim_reg) begin
                            halted      = 1'b1;
                            status_next = ST_POWER;
                        end
                    end else begin
                        power_cnt_next = '0;
                    end
                end
                // reflected power high, enable read live
                if (!halted && reflect_tol_reg != '0) begin
                    if (band_reflect_next < tick.reflect_x100) begin
                        reflect_cnt_next = sat_inc(reflect_cnt_next);
                        if (reflect_cnt_next > power_lim_reg) begin
                            halted      = 1'b1;
                            status_next = ST_REFLECT;
                        end
                    end else begin
                        reflect_cnt_next = '0;
                    end
                end
            end
            // abort unless an alarm already fired
            if (!halted && tick.stop) begin
                halted      = 1'b1;
                status_next = ST_ABORT;
            end
            if (halted) begin
                phase_next = PH_HALT;
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            phase_reg        <= PH_IDLE;
            status_reg       <= ST_IDLE;
            band_power_reg   <= '0;
            band_reflect_reg <= '0;
            plasma_cnt_reg   <= '0;
            power_cnt_reg    <= '0;
            reflect_cnt_reg  <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (move) begin
                phase_reg        <= phase_next;
                status_reg       <= status_next;
                band_power_reg   <= band_power_next;
                band_reflect_reg <= band_reflect_next;
                plasma_cnt_reg   <= plasma_cnt_next;
                power_cnt_reg    <= power_cnt_next;
                reflect_cnt_reg  <= reflect_cnt_next;
            end
        end
    end

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_tol_reg   <= PCT_W'(10);
            reflect_tol_reg <= PCT_W'(10);
            plasma_lim_reg  <= LIM_W'(3);
            power_lim_reg   <= LIM_W'(3);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_POWER_TOL:   power_tol_reg   <= cfg_data[PCT_W-1:0];
                REG_REFLECT_TOL: reflect_tol_reg <= cfg_data[PCT_W-1:0];
                REG_PLASMA_LIM:  plasma_lim_reg  <= cfg_data[LIM_W-1:0];
                REG_POWER_LIM:   power_lim_reg   <= cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // result
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({reflect_cnt_reg, power_cnt_reg, plasma_cnt_reg,
                                       status_reg});

endmodule

// ===== rtl/rfgfm_checker.sv =====
// port-level checker for the rf generator fault monitor, bound to the top level
// depends on rfgfm_pkg and rf_generator_fault_monitor_defines.svh
`include "rf_generator_fault_monitor_defines.svh"

module rfgfm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [rfgfm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input logic [rfgfm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rfgfm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [rfgfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [rfgfm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rfgfm_pkg::*;

    logic [ST_W-1:0]  st;
    logic [CNT_W-1:0] pc, wc, rc;

    // result fields
    assign st = m_axis_tdata[ST_W-1:0];
    assign pc = m_axis_tdata[ST_W+CNT_W-1:ST_W];
    assign wc = m_axis_tdata[ST_W+2*CNT_W-1:ST_W+CNT_W];
    assign rc = m_axis_tdata[ST_W+3*CNT_W-1:ST_W+2*CNT_W];

    // no result right after reset
    `RFGFM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_axis_tvalid)

    // stalled result holds
    `RFGFM_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
                       m_axis_tvalid && $stable(m_axis_tdata))

    // an idle monitor never counted anything
    `RFGFM_ASSERT_IMPL(a_idle_clear, aclk, aresetn, m_axis_tvalid && st == ST_IDLE,
                       pc == '0 && wc == '0 && rc == '0)

    // each alarm shows a nonzero count behind it
    `RFGFM_ASSERT_IMPL(a_alarm_count, aclk, aresetn,
                       m_axis_tvalid && (st == ST_NOPLASMA || st == ST_POWER ||
                                         st == ST_REFLECT),
                       (st != ST_NOPLASMA || pc != '0) && (st != ST_POWER || wc != '0) &&
                       (st != ST_REFLECT || rc != '0))

endmodule

bind rf_generator_fault_monitor rfgfm_checker u_rfgfm_checker (.*);
